// ===== design/swhsr_pkg.sv =====
// ----------------------------------------------------------------------------
// swhsr_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_START_LOW  = 2'd0;
	localparam logic [1:0] CFG_START_HIGH = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT    = 2'd2;
	localparam logic [1:0] CFG_ONE_THRESH = 2'd3;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	// Reset values of the configuration registers
	localparam logic [15:0] START_LOW_RESET  = 16'd18000;
	localparam logic [7:0]  START_HIGH_RESET = 8'd30;
	localparam logic [7:0]  TIMEOUT_RESET    = 8'd200;
	localparam logic [7:0]  ONE_THRESH_RESET = 8'd20;

	// Pin drive codes
	localparam logic [1:0] DRIVE_RELEASE = 2'd0;
	localparam logic [1:0] DRIVE_LOW     = 2'd1;
	localparam logic [1:0] DRIVE_HIGH    = 2'd2;

	// Protocol constants
	localparam logic [6:0]  PHASES_TOTAL     = 7'd83;
	localparam logic [6:0]  FIRST_DATA_PHASE = 7'd4;
	localparam logic [5:0]  DATA_BITS        = 6'd40;
	localparam logic [15:0] TICK_MAX         = 16'hFFFF;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  start_high_ticks;
		logic [7:0]  timeout_ticks;
		logic [7:0]  one_threshold;
	} cfg_t;

	typedef struct packed {
		logic command;
		logic pin_level;
	} sample_t;

	typedef struct packed {
		logic [1:0] pin_drive;
		logic       busy_res;
		logic       done_res;
		logic       read_ok;
		logic       timed_out;
		logic [5:0] bits_received;
		logic [7:0] humidity_int;
		logic [7:0] humidity_frac;
		logic [7:0] temp_int;
		logic [7:0] temp_frac;
	} result_t;

endpackage

// ===== design/swhsr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// swhsr_cfg_regs
// Configuration register file: four timing registers written by index.
// ----------------------------------------------------------------------------
module swhsr_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swhsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output swhsr_pkg::cfg_t                      cfg
);
	import swhsr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks  <= START_LOW_RESET;
			cfg_q.start_high_ticks <= START_HIGH_RESET;
			cfg_q.timeout_ticks    <= TIMEOUT_RESET;
			cfg_q.one_threshold    <= ONE_THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START_LOW:  cfg_q.start_low_ticks  <= cfg_data;
				CFG_START_HIGH: cfg_q.start_high_ticks <= cfg_data[7:0];
				CFG_TIMEOUT:    cfg_q.timeout_ticks    <= cfg_data[7:0];
				CFG_ONE_THRESH: cfg_q.one_threshold    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/single_wire_humidity_sensor_reader_core.sv =====
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_core
// Single-wire humidity/temperature sensor reader with a tick-driven sequencer.
// ----------------------------------------------------------------------------
// Each sample beat is one microsecond tick carrying the sampled data-pin level,
// or a start command. A start while idle drives the pin low for
// start_low_ticks ticks, then high for start_high_ticks ticks (each drive
// phase lasts at least one tick), then releases the pin and times each level
// of the sensor's answer. Of the 83 level phases, every even phase from the
// fifth on shifts in one data bit: a one when the phase lasted more than
// one_threshold ticks. A level that lasts timeout_ticks ticks aborts the read
// and sets timed_out. After the last phase read_ok reports whether all forty
// bits arrived and the fifth byte matches the low byte of the sum of the
// first four. Every sample beat yields exactly one result beat showing the
// state after that tick; the data bytes show the partial shift contents while
// a read runs. A start seen while busy is treated as a plain tick. The block
// takes one sample beat per clock cycle while the result is not stalled: the
// sample is captured in an input register, and the sequencer update is a
// single pass of logic from there into the result register. A stalled result
// holds the result register and the input register absorbs one more beat
// before sample_stall rises. Configuration writes are always ready and must
// be made while no read is in progress.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample channel
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  swhsr_pkg::sample_t                 sample,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output swhsr_pkg::result_t                 result,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swhsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import swhsr_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_LOW,
		MODE_HIGH,
		MODE_MEASURE
	} mode_t;

	cfg_t cfg;

	swhsr_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register and result register
	sample_t item_s1;
	logic    item_valid_s1;
	result_t result_q;
	logic    result_valid_q;

	// Sequencer state
	mode_t       mode_q;
	logic [15:0] tick_q;
	logic        level_q;
	logic [6:0]  phase_q;
	logic [5:0]  bits_q;
	logic [39:0] shift_q;
	logic        ok_q;
	logic        tout_q;

	// Next-state values
	mode_t       mode_d;
	logic [15:0] tick_d;
	logic        level_d;
	logic [6:0]  phase_d;
	logic [5:0]  bits_d;
	logic [39:0] shift_d;
	logic        ok_d;
	logic        tout_d;
	logic        done_d;
	logic [7:0]  sum_d;
	logic [1:0]  drive_d;

	logic advance;

	// Move the held sample into the result register when that slot frees up.
	assign advance      = item_valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = item_valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		mode_d  = mode_q;
		tick_d  = tick_q;
		level_d = level_q;
		phase_d = phase_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		ok_d    = ok_q;
		tout_d  = tout_q;
		done_d  = 1'b0;
		sum_d   = 8'd0;

		unique case (mode_q)
			MODE_IDLE: begin
				// Start a read: clear the data and status, drive low.
				if (item_s1.command) begin
					mode_d  = MODE_LOW;
					tick_d  = 16'd0;
					level_d = 1'b1;
					phase_d = 7'd0;
					bits_d  = 6'd0;
					shift_d = 40'd0;
					ok_d    = 1'b0;
					tout_d  = 1'b0;
				end
			end
			MODE_LOW: begin
				tick_d = tick_q + 16'd1;
				if (tick_d >= cfg.start_low_ticks) begin
					mode_d = MODE_HIGH;
					tick_d = 16'd0;
				end
			end
			MODE_HIGH: begin
				tick_d = tick_q + 16'd1;
				if (tick_d >= {8'd0, cfg.start_high_ticks}) begin
					mode_d  = MODE_MEASURE;
					tick_d  = 16'd0;
					level_d = 1'b1;
					phase_d = 7'd0;
				end
			end
			MODE_MEASURE: begin
				if (item_s1.pin_level == level_q) begin
					// Same level: count (saturating) and check the timeout.
					if (tick_q != TICK_MAX) begin
						tick_d = tick_q + 16'd1;
					end
					if (tick_d >= {8'd0, cfg.timeout_ticks}) begin
						mode_d = MODE_IDLE;
						tick_d = 16'd0;
						ok_d   = 1'b0;
						tout_d = 1'b1;
						done_d = 1'b1;
					end
				end else begin
					// Level change closes a phase; even data phases carry a bit.
					if (phase_q >= FIRST_DATA_PHASE && !phase_q[0] && bits_q < DATA_BITS) begin
						shift_d = {shift_q[38:0], tick_q > {8'd0, cfg.one_threshold}};
						bits_d  = bits_q + 6'd1;
					end
					level_d = item_s1.pin_level;
					tick_d  = 16'd0;
					phase_d = phase_q + 7'd1;
					if (phase_d >= PHASES_TOTAL) begin
						sum_d  = shift_d[39:32] + shift_d[31:24] + shift_d[23:16]
						       + shift_d[15:8];
						mode_d = MODE_IDLE;
						ok_d   = (bits_d >= DATA_BITS) && (shift_d[7:0] == sum_d);
						tout_d = 1'b0;
						done_d = 1'b1;
					end
				end
			end
			default: ;
		endcase

		unique case (mode_d)
			MODE_LOW:  drive_d = DRIVE_LOW;
			MODE_HIGH: drive_d = DRIVE_HIGH;
			default:   drive_d = DRIVE_RELEASE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
			mode_q         <= MODE_IDLE;
			tick_q         <= 16'd0;
			level_q        <= 1'b1;
			phase_q        <= 7'd0;
			bits_q         <= 6'd0;
			shift_q        <= 40'd0;
			ok_q           <= 1'b0;
			tout_q         <= 1'b0;
		end else begin
			// Take a sample beat whenever the input register is free or moving on.
			if (!sample_stall) begin
				item_valid_s1 <= sample_valid;
				if (sample_valid) begin
					item_s1 <= sample;
				end
			end

			// Drop the result once taken, unless a new one replaces it.
			if (result_valid_q && !result_stall && !advance) begin
				result_valid_q <= 1'b0;
			end

			if (advance) begin
				mode_q         <= mode_d;
				tick_q         <= tick_d;
				level_q        <= level_d;
				phase_q        <= phase_d;
				bits_q         <= bits_d;
				shift_q        <= shift_d;
				ok_q           <= ok_d;
				tout_q         <= tout_d;
				result_valid_q <= 1'b1;

				result_q.pin_drive     <= drive_d;
				result_q.busy_res      <= (mode_d != MODE_IDLE);
				result_q.done_res      <= done_d;
				result_q.read_ok       <= ok_d;
				result_q.timed_out     <= tout_d;
				result_q.bits_received <= bits_d;
				result_q.humidity_int  <= shift_d[39:32];
				result_q.humidity_frac <= shift_d[31:24];
				result_q.temp_int      <= shift_d[23:16];
				result_q.temp_frac     <= shift_d[15:8];
			end
		end
	end

	// A held sample that could not advance stays put for the next cycle.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !advance |=> item_valid_s1 && $stable(item_s1))
		else $error("input register lost or changed a held sample");

	// A finished read is never reported as still busy.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.done_res |-> !result_q.busy_res)
		else $error("done pulse while busy");

	// The two status flags exclude each other.
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ok_q && tout_q))
		else $error("read_ok and timed_out both set");

	// Never more than forty data bits.
	a_bits_max: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= DATA_BITS)
		else $error("bit count beyond forty");

	// The pin is only driven during a read.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.pin_drive != DRIVE_RELEASE |-> result_q.busy_res)
		else $error("pin driven while idle");

endmodule
